// ----- design/mtt_pkg.sv -----
// shared types, constants and helpers for the multi-tape turing step engine
package mtt_pkg;

  // fixed geometry
  localparam int NUM_TAPES  = 2;
  localparam int RULE_SLOTS = 64;
  localparam int SYM_W      = 8;
  localparam int STATE_W    = 6;
  localparam int POS_W      = 12;
  localparam int SPAN_W     = 13;
  localparam int TAPE_CELLS = 4096;
  localparam int TAPE_AW    = 12;
  localparam int CELL_W     = SYM_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // item commands
  typedef enum logic [2:0] {
    CMD_LOAD   = 3'd0,
    CMD_WRCELL = 3'd1,
    CMD_START  = 3'd2,
    CMD_STEP   = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  // run status codes
  localparam logic [1:0] RUN_ACTIVE  = 2'd0;
  localparam logic [1:0] RUN_ACCEPT  = 2'd1;
  localparam logic [1:0] RUN_NORULE  = 2'd2;
  localparam logic [1:0] RUN_OFFTAPE = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPES  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT = 2'd3;

  // head move codes
  localparam logic [1:0] MOVE_LEFT  = 2'd1;
  localparam logic [1:0] MOVE_RIGHT = 2'd2;

  // one rule table entry
  typedef struct packed {
    logic [STATE_W-1:0]         st;
    logic [NUM_TAPES*SYM_W-1:0] match;
    logic [NUM_TAPES*SYM_W-1:0] wsym;
    logic [2*NUM_TAPES-1:0]     moves;
    logic [STATE_W-1:0]         nst;
  } rule_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic load_rule;
    logic write_cell;
    logic do_start;
    logic clear_wr;
    logic key_cap;
    logic scan_run;
    logic apply;
    logic cell_rd;
    logic cell_cap;
    logic result_cap;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic halted;
    logic clear_last;
    logic hit;
    logic miss;
  } dp_sts_t;

  // signed position to memory address: offset by half the tape
  function automatic logic [TAPE_AW-1:0] pos_addr(input logic [POS_W-1:0] pos);
    pos_addr = {~pos[POS_W-1], pos[POS_W-2:0]};
  endfunction

  // stored cell to symbol, blank when never written
  function automatic logic [SYM_W-1:0] cell_val(input logic [CELL_W-1:0] c,
                                                input logic [SYM_W-1:0] blank);
    cell_val = c[CELL_W-1] ? c[SYM_W-1:0] : blank;
  endfunction

endpackage

// ----- design/multi_tape_turing_step_engine_top.sv -----
// top level of the multi-tape turing step engine
// Items go in with start while busy is low; each item returns exactly one result,
// shown for one cycle with done_o, and the receiver cannot stall it. Timing is set by
// the controller sequence around the tape memories, which have registered reads, and
// the rule table scan. Load rule, write cell, unknown commands and a step on a halted
// machine go straight to the result capture; read cell first reads and captures the
// cell; a running step captures the key, scans the table one slot a cycle until the
// lowest matching slot stops it or the last slot misses, then applies a hit.
// Start clears the written marks of all 4096 cells of both tapes, one position a
// cycle; the same clearing pass runs after reset, with busy high. Configuration writes
// are always taken (cfg_ready_o stays high) and belong between items.
module multi_tape_turing_step_engine_top
  import mtt_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  output logic                          done_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic [2:0]                    cmd_i,
  input  logic [5:0]                    rule_index_i,
  input  logic                          rule_valid_i,
  input  logic [STATE_W-1:0]            match_state_i,
  input  logic [NUM_TAPES*SYM_W-1:0]    match_symbols_i,
  input  logic [NUM_TAPES*SYM_W-1:0]    write_symbols_i,
  input  logic [2*NUM_TAPES-1:0]        head_moves_i,
  input  logic [STATE_W-1:0]            next_state_i,
  input  logic                          tape_select_i,
  input  logic signed [POS_W-1:0]       cell_position_i,
  input  logic [SYM_W-1:0]              cell_symbol_i,
  output logic [1:0]                    run_status_o,
  output logic [STATE_W-1:0]            current_state_o,
  output logic [31:0]                   steps_taken_o,
  output logic [NUM_TAPES*SYM_W-1:0]    heads_symbols_o,
  output logic [SYM_W-1:0]              read_symbol_o,
  output logic signed [POS_W-1:0]       head_position_o,
  output logic signed [SPAN_W-1:0]      span_low_o,
  output logic signed [SPAN_W-1:0]      span_high_o
);

  dp_cmd_t ctl;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  // sequencing
  mtt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_i   (cmd_i),
    .sts_i   (sts),
    .ctl_o   (ctl),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // storage and arithmetic
  mtt_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .rule_index_i    (rule_index_i),
    .rule_valid_i    (rule_valid_i),
    .match_state_i   (match_state_i),
    .match_symbols_i (match_symbols_i),
    .write_symbols_i (write_symbols_i),
    .head_moves_i    (head_moves_i),
    .next_state_i    (next_state_i),
    .tape_select_i   (tape_select_i),
    .cell_position_i (cell_position_i),
    .cell_symbol_i   (cell_symbol_i),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .run_status_o    (run_status_o),
    .current_state_o (current_state_o),
    .steps_taken_o   (steps_taken_o),
    .heads_symbols_o (heads_symbols_o),
    .read_symbol_o   (read_symbol_o),
    .head_position_o (head_position_o),
    .span_low_o      (span_low_o),
    .span_high_o     (span_high_o)
  );

endmodule

// ----- design/mtt_ctrl.sv -----
// controller state machine sequencing each item through the datapath
module mtt_ctrl
  import mtt_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [2:0]    cmd_i,
  input  dp_sts_t       sts_i,
  output dp_cmd_t       ctl_o,
  output logic          busy_o,
  output logic          done_o
);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_KRD   = 10'b0000000100,
    S_KWAIT = 10'b0000001000,
    S_SCAN  = 10'b0000010000,
    S_APPLY = 10'b0000100000,
    S_CRD   = 10'b0001000000,
    S_CWAIT = 10'b0010000000,
    S_HRD   = 10'b0100000000,
    S_HWAIT = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   reply_q, reply_d;
  logic   done_q, done_d;

  // next state and command decode
  always_comb begin
    state_d = state_q;
    reply_d = reply_q;
    done_d  = 1'b0;
    ctl_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        ctl_o.clear_wr = 1'b1;
        if (sts_i.clear_last) begin
          state_d = reply_q ? S_HRD : S_IDLE;
          reply_d = 1'b0;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          ctl_o.accept = 1'b1;
          unique case (cmd_i)
            CMD_LOAD: begin
              ctl_o.load_rule = 1'b1;
              state_d = S_HRD;
            end
            CMD_WRCELL: begin
              ctl_o.write_cell = 1'b1;
              state_d = S_HRD;
            end
            CMD_START: begin
              ctl_o.do_start = 1'b1;
              reply_d = 1'b1;
              state_d = S_CLEAR;
            end
            CMD_STEP: state_d = sts_i.halted ? S_HRD : S_KRD;
            CMD_READ: state_d = S_CRD;
            default:  state_d = S_HRD;
          endcase
        end
      end
      S_KRD:   state_d = S_KWAIT;
      S_KWAIT: begin
        ctl_o.key_cap = 1'b1;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        ctl_o.scan_run = 1'b1;
        if (sts_i.hit) begin
          state_d = S_APPLY;
        end else if (sts_i.miss) begin
          state_d = S_HRD;
        end
      end
      S_APPLY: begin
        ctl_o.apply = 1'b1;
        state_d = S_HRD;
      end
      S_CRD: begin
        ctl_o.cell_rd = 1'b1;
        state_d = S_CWAIT;
      end
      S_CWAIT: begin
        ctl_o.cell_cap = 1'b1;
        state_d = S_HRD;
      end
      S_HRD:   state_d = S_HWAIT;
      S_HWAIT: begin
        ctl_o.result_cap = 1'b1;
        done_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      reply_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      reply_q <= reply_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  // result strobe only after the result capture cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == S_HWAIT))
    else $error("result strobe without capture");

  // an accepted item always leaves idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q != S_IDLE))
    else $error("accepted item not started");

  // a rule hit during the scan is applied next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && sts_i.hit) |=> (state_q == S_APPLY))
    else $error("rule hit not applied");

endmodule

// ----- design/mtt_dp.sv -----
// datapath: configuration, rule table, tape memories, heads, spans and results
module mtt_dp
  import mtt_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic [5:0]                    rule_index_i,
  input  logic                          rule_valid_i,
  input  logic [STATE_W-1:0]            match_state_i,
  input  logic [NUM_TAPES*SYM_W-1:0]    match_symbols_i,
  input  logic [NUM_TAPES*SYM_W-1:0]    write_symbols_i,
  input  logic [2*NUM_TAPES-1:0]        head_moves_i,
  input  logic [STATE_W-1:0]            next_state_i,
  input  logic                          tape_select_i,
  input  logic signed [POS_W-1:0]       cell_position_i,
  input  logic [SYM_W-1:0]              cell_symbol_i,
  input  dp_cmd_t                       ctl_i,
  output dp_sts_t                       sts_o,
  output logic [1:0]                    run_status_o,
  output logic [STATE_W-1:0]            current_state_o,
  output logic [31:0]                   steps_taken_o,
  output logic [NUM_TAPES*SYM_W-1:0]    heads_symbols_o,
  output logic [SYM_W-1:0]              read_symbol_o,
  output logic signed [POS_W-1:0]       head_position_o,
  output logic signed [SPAN_W-1:0]      span_low_o,
  output logic signed [SPAN_W-1:0]      span_high_o
);

  localparam int RIW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int SCW = $clog2(RULE_SLOTS + 1);

  // configuration registers
  logic [SYM_W-1:0]      blank_q;
  logic [STATE_W-1:0]    start_state_q;
  logic [1:0]            tapes_q;
  logic [CFG_DATA_W-1:0] accept_q;

  // machine state
  logic [STATE_W-1:0]     mstate_q;
  logic signed [POS_W-1:0]  head_q [NUM_TAPES];
  logic signed [SPAN_W-1:0] lo_q   [NUM_TAPES];
  logic signed [SPAN_W-1:0] hi_q   [NUM_TAPES];
  logic [31:0]            steps_q;
  logic [1:0]             halt_q;

  // item latches and scan state
  logic                    sel_q;
  logic [POS_W-1:0]        pos_q;
  logic [SYM_W-1:0]        rsym_q;
  logic [SYM_W-1:0]        key_q [NUM_TAPES];
  logic [SCW-1:0]          scan_q;
  logic                    cmp_vld_q;
  logic [RIW-1:0]          cmp_idx_q;
  rule_t                   rule_q;
  rule_t                   rule_rd_q;
  logic [TAPE_AW-1:0]      clr_q;
  logic                    rule_valid_q [RULE_SLOTS];
  rule_t                   rule_mem [RULE_SLOTS];

  logic two_tapes;
  assign two_tapes = tapes_q[1];

  // tape memory port signals
  logic               tw_en   [NUM_TAPES];
  logic [TAPE_AW-1:0] tw_addr [NUM_TAPES];
  logic [CELL_W-1:0]  tw_data [NUM_TAPES];
  logic [TAPE_AW-1:0] tr_addr [NUM_TAPES];
  logic [CELL_W-1:0]  tr_data [NUM_TAPES];

  // step move evaluation
  logic signed [SPAN_W-1:0] newpos [NUM_TAPES];
  logic                     off_tape;
  logic                     apply_ok;

  always_comb begin
    off_tape = 1'b0;
    for (int t = 0; t < NUM_TAPES; t++) begin
      logic [1:0] mv;
      mv = rule_q.moves[2*t +: 2];
      newpos[t] = SPAN_W'(head_q[t]);
      if (mv == MOVE_LEFT) begin
        newpos[t] = SPAN_W'(head_q[t]) - SPAN_W'(1);
      end else if (mv == MOVE_RIGHT) begin
        newpos[t] = SPAN_W'(head_q[t]) + SPAN_W'(1);
      end
      if ((t == 0 || two_tapes) && (newpos[t][SPAN_W-1] != newpos[t][SPAN_W-2])) begin
        off_tape = 1'b1;
      end
    end
  end
  assign apply_ok = ctl_i.apply && !off_tape;

  // tape memory port muxing
  always_comb begin
    for (int t = 0; t < NUM_TAPES; t++) begin
      tw_en[t]   = 1'b0;
      tw_addr[t] = pos_addr(head_q[t]);
      tw_data[t] = {1'b1, rule_q.wsym[SYM_W*t +: SYM_W]};
      tr_addr[t] = ctl_i.cell_rd ? pos_addr(pos_q) : pos_addr(head_q[t]);
      if (ctl_i.clear_wr) begin
        tw_en[t]   = 1'b1;
        tw_addr[t] = clr_q;
        tw_data[t] = '0;
      end else if (ctl_i.write_cell) begin
        tw_en[t]   = (tape_select_i == 1'(t));
        tw_addr[t] = pos_addr(cell_position_i);
        tw_data[t] = {1'b1, cell_symbol_i};
      end else if (apply_ok) begin
        tw_en[t]   = (t == 0) || two_tapes;
      end
    end
  end

  // tape memories, one per tape
  for (genvar gt = 0; gt < NUM_TAPES; gt++) begin : g_tape
    logic [CELL_W-1:0] mem [TAPE_CELLS];
    logic [CELL_W-1:0] rd_q;
    always_ff @(posedge clk_i) begin
      if (tw_en[gt]) begin
        mem[tw_addr[gt]] <= tw_data[gt];
      end
      rd_q <= mem[tr_addr[gt]];
    end
    assign tr_data[gt] = rd_q;
  end

  // rule table memory with registered read at the scan index
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_rule && ({1'b0, rule_index_i} < 7'(RULE_SLOTS))) begin
      rule_mem[rule_index_i[RIW-1:0]] <= '{st: match_state_i, match: match_symbols_i,
                                           wsym: write_symbols_i, moves: head_moves_i,
                                           nst: next_state_i};
    end
    rule_rd_q <= rule_mem[scan_q[RIW-1:0]];
  end

  // rule compare on the registered entry
  logic hit, miss;
  always_comb begin
    hit = cmp_vld_q && rule_valid_q[cmp_idx_q] && (rule_rd_q.st == mstate_q)
          && (rule_rd_q.match[SYM_W-1:0] == key_q[0])
          && (!two_tapes || (rule_rd_q.match[2*SYM_W-1:SYM_W] == key_q[1]));
    miss = cmp_vld_q && !hit && (cmp_idx_q == RIW'(RULE_SLOTS - 1));
  end

  assign sts_o.halted     = (halt_q != RUN_ACTIVE);
  assign sts_o.clear_last = (clr_q == '1);
  assign sts_o.hit        = hit;
  assign sts_o.miss       = miss;

  // rule valid marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < RULE_SLOTS; r++) rule_valid_q[r] <= 1'b0;
    end else if (ctl_i.load_rule && ({1'b0, rule_index_i} < 7'(RULE_SLOTS))) begin
      rule_valid_q[rule_index_i[RIW-1:0]] <= rule_valid_i;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_q       <= 8'd95;
      start_state_q <= '0;
      tapes_q       <= 2'd1;
      accept_q      <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BLANK:  blank_q       <= cfg_data_i[SYM_W-1:0];
        CFG_START:  start_state_q <= cfg_data_i[STATE_W-1:0];
        CFG_TAPES:  tapes_q       <= cfg_data_i[1:0];
        CFG_ACCEPT: accept_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // machine state, scan control and clearing counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mstate_q  <= '0;
      steps_q   <= '0;
      halt_q    <= RUN_ACTIVE;
      clr_q     <= '0;
      scan_q    <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
      for (int t = 0; t < NUM_TAPES; t++) begin
        head_q[t] <= '0;
        lo_q[t]   <= '0;
        hi_q[t]   <= '0;
      end
    end else begin
      if (ctl_i.clear_wr) begin
        clr_q <= clr_q + TAPE_AW'(1);
      end
      if (ctl_i.do_start) begin
        mstate_q <= start_state_q;
        steps_q  <= '0;
        halt_q   <= RUN_ACTIVE;
        clr_q    <= '0;
        for (int t = 0; t < NUM_TAPES; t++) begin
          head_q[t] <= '0;
          lo_q[t]   <= '0;
          hi_q[t]   <= '0;
        end
      end
      // write cell widens the span of its tape
      if (ctl_i.write_cell) begin
        for (int t = 0; t < NUM_TAPES; t++) begin
          if (tape_select_i == 1'(t)) begin
            if (SPAN_W'(cell_position_i) < lo_q[t]) lo_q[t] <= SPAN_W'(cell_position_i);
            if (SPAN_W'(cell_position_i) + SPAN_W'(1) > hi_q[t]) begin
              hi_q[t] <= SPAN_W'(cell_position_i) + SPAN_W'(1);
            end
          end
        end
      end
      // rule scan, one entry issued per cycle
      if (ctl_i.key_cap) begin
        scan_q    <= '0;
        cmp_vld_q <= 1'b0;
      end else if (ctl_i.scan_run) begin
        if (scan_q < SCW'(RULE_SLOTS)) begin
          cmp_vld_q <= 1'b1;
          cmp_idx_q <= scan_q[RIW-1:0];
          scan_q    <= scan_q + SCW'(1);
        end else begin
          cmp_vld_q <= 1'b0;
        end
        if (miss) halt_q <= RUN_NORULE;
      end
      // apply the matched rule
      if (ctl_i.apply) begin
        if (off_tape) begin
          halt_q <= RUN_OFFTAPE;
        end else begin
          for (int t = 0; t < NUM_TAPES; t++) begin
            if (t == 0 || two_tapes) begin
              head_q[t] <= newpos[t][POS_W-1:0];
              if (newpos[t] < lo_q[t]) lo_q[t] <= newpos[t];
              if (newpos[t] + SPAN_W'(1) > hi_q[t]) hi_q[t] <= newpos[t] + SPAN_W'(1);
            end
          end
          mstate_q <= rule_q.nst;
          if (steps_q != '1) steps_q <= steps_q + 32'd1;
          if (accept_q[rule_q.nst]) halt_q <= RUN_ACCEPT;
        end
      end
    end
  end

  // item latches, key, hit rule and result registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      sel_q  <= tape_select_i;
      pos_q  <= cell_position_i;
      rsym_q <= '0;
    end
    if (ctl_i.key_cap) begin
      for (int t = 0; t < NUM_TAPES; t++) key_q[t] <= cell_val(tr_data[t], blank_q);
    end
    if (ctl_i.scan_run && hit) begin
      rule_q <= rule_rd_q;
    end
    if (ctl_i.cell_cap) begin
      rsym_q <= cell_val(tr_data[sel_q], blank_q);
    end
    if (ctl_i.result_cap) begin
      run_status_o    <= halt_q;
      current_state_o <= mstate_q;
      steps_taken_o   <= steps_q;
      heads_symbols_o <= {two_tapes ? cell_val(tr_data[1], blank_q) : SYM_W'(0),
                          cell_val(tr_data[0], blank_q)};
      read_symbol_o   <= rsym_q;
      head_position_o <= head_q[sel_q];
      span_low_o      <= lo_q[sel_q];
      span_high_o     <= hi_q[sel_q];
    end
  end

  // hit and miss never together
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(hit && miss))
    else $error("rule hit and miss together");

  // a step that moved off the tape leaves the off-tape status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.apply && off_tape) |=> (halt_q == RUN_OFFTAPE))
    else $error("off-tape step not flagged");

  // a miss during the scan reports no matching rule
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.scan_run && miss) |=> (halt_q == RUN_NORULE))
    else $error("rule miss not flagged");

endmodule
